// ----- rtl/core/phfd_pkg.sv -----
// shared types, constants and register codes of the pixel hit fragment deframer
`default_nettype none

package phfd_pkg;

    localparam int unsigned MAX_CHIP_SLOTS_DEF = 16;
    localparam int unsigned QUEUE_DEPTH_DEF    = 4;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_FRONT_END_TYPE      = 3'd0;
    localparam logic [2:0] CFG_PRODUCER_NUMBER     = 3'd1;
    localparam logic [2:0] CFG_QUAD_MODULE_MASK    = 3'd2;
    localparam logic [2:0] CFG_CHIP_LOCATION_TABLE = 3'd3;
    localparam logic [2:0] CFG_MODULE_INDEX_TABLE  = 3'd4;

    // front end generations
    localparam logic [1:0] FE_OLDER    = 2'd0;
    localparam logic [1:0] FE_NEWER    = 2'd1;
    localparam logic [1:0] FE_NEWEST   = 2'd2;
    localparam logic [1:0] FE_RESERVED = 2'd3;

    // chip locations on a quad module
    localparam logic [2:0] LOC_1 = 3'd1;
    localparam logic [2:0] LOC_2 = 3'd2;
    localparam logic [2:0] LOC_3 = 3'd3;
    localparam logic [2:0] LOC_4 = 3'd4;

    // byte positions in the fragment header
    localparam logic [3:0] POS_TAG_B0  = 4'd0;
    localparam logic [3:0] POS_TAG_B1  = 4'd1;
    localparam logic [3:0] POS_TAG_B2  = 4'd2;
    localparam logic [3:0] POS_TAG_B3  = 4'd3;
    localparam logic [3:0] POS_TRIG_LO = 4'd4;
    localparam logic [3:0] POS_TRIG_HI = 4'd5;
    localparam logic [3:0] POS_BCID_LO = 4'd6;
    localparam logic [3:0] POS_BCID_HI = 4'd7;
    localparam logic [3:0] POS_CNT_LO  = 4'd8;
    localparam logic [3:0] POS_CNT_HI  = 4'd9;

    // byte positions in a hit
    localparam logic [3:0] POS_COL_LO = 4'd0;
    localparam logic [3:0] POS_COL_HI = 4'd1;
    localparam logic [3:0] POS_ROW_LO = 4'd2;
    localparam logic [3:0] POS_ROW_HI = 4'd3;
    localparam logic [3:0] POS_CHG_LO = 4'd4;
    localparam logic [3:0] POS_CHG_HI = 4'd5;

    // geometry and plane numbering
    localparam logic [15:0] QUAD_HALF_COLS = 16'd384;
    localparam logic [15:0] QUAD_FULL_ROWS = 16'd800;
    localparam logic [15:0] CHIP_ROWS_SPAN = 16'd400;
    localparam logic [12:0] PLANE_BASE     = 13'd110;

    typedef struct packed {
        logic [1:0]  front_end_type;
        logic [7:0]  producer_number;
        logic [15:0] quad_module_mask;
        logic [47:0] chip_location_table;
        logic [63:0] module_index_table;
    } t_cfg;

    typedef struct packed {
        logic        err;
        logic [3:0]  slot;
        logic [15:0] hit_col;
        logic [15:0] hit_row;
        logic [15:0] charge;
        logic [31:0] label;
    } t_hit_rec;

endpackage

`default_nettype wire

// ----- rtl/core/phfd_channels.sv -----
// handshake channels of the deframer: byte input, pixel output, register writes
`default_nettype none

interface phfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [3:0] chip_slot;
    logic       first_of_block;

    modport source (output valid, output data_byte, output chip_slot,
                    output first_of_block, input ready);
    modport sink   (input valid, input data_byte, input chip_slot,
                    input first_of_block, output ready);
endinterface

interface phfd_out_if;
    logic        valid;
    logic        ready;
    logic [12:0] plane_id;
    logic [15:0] pixel_col;
    logic [15:0] pixel_row;
    logic [15:0] charge;
    logic [31:0] trigger_label;
    logic        error;

    modport source (output valid, output plane_id, output pixel_col, output pixel_row,
                    output charge, output trigger_label, output error, input ready);
    modport sink   (input valid, input plane_id, input pixel_col, input pixel_row,
                    input charge, input trigger_label, input error, output ready);
endinterface

interface phfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/phfd_front.sv -----
// byte parser: assembles fragment headers and hits, checks mapping, pushes hit records
`default_nettype none

module phfd_front
    import phfd_pkg::*;
#(
    parameter int unsigned MAX_CHIP_SLOTS = MAX_CHIP_SLOTS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_space,
    phfd_in_if.sink       i_in,
    output logic          o_push,
    output t_hit_rec      o_rec
);

    logic [3:0]  r_pos,  n_pos;
    logic        r_in_hits, n_in_hits;
    logic [15:0] r_hits, n_hits;
    logic [31:0] r_tag,  n_tag;
    logic [15:0] r_trig, n_trig;
    logic [15:0] r_col,  n_col;
    logic [15:0] r_row,  n_row;
    logic [7:0]  r_cnt,  n_cnt;
    logic        r_drop, n_drop;

    logic        accept;
    logic [3:0]  e_pos;
    logic        e_in_hits;
    logic [15:0] e_hits;
    logic        e_drop;
    logic [15:0] hits_dec;
    logic [15:0] count_word;
    logic [7:0]  b;
    logic [3:0]  slot;
    logic        slot_bad;
    logic        quad;
    logic [2:0]  loc;
    logic        loc_ok;
    logic        map_err;

    assign i_in.ready = i_space;
    assign accept     = i_in.valid && i_space;
    assign b          = i_in.data_byte;
    assign slot       = i_in.chip_slot;

    assign e_pos      = i_in.first_of_block ? 4'd0  : r_pos;
    assign e_in_hits  = i_in.first_of_block ? 1'b0  : r_in_hits;
    assign e_hits     = i_in.first_of_block ? 16'd0 : r_hits;
    assign e_drop     = i_in.first_of_block ? 1'b0  : r_drop;
    assign hits_dec   = e_hits - 16'd1;
    assign count_word = {b, r_cnt};

    // mapping check for the slot of the hit's last byte
    assign slot_bad = 32'(slot) >= MAX_CHIP_SLOTS;
    assign quad     = i_cfg.quad_module_mask[slot];
    assign loc      = i_cfg.chip_location_table[3*slot +: 3];
    assign loc_ok   = (loc == LOC_1) || (loc == LOC_2) || (loc == LOC_3) || (loc == LOC_4);
    assign map_err  = slot_bad || (i_cfg.front_end_type == FE_RESERVED)
                      || (quad && ((i_cfg.front_end_type == FE_OLDER) || !loc_ok));

    always_comb begin
        n_pos     = r_pos;
        n_in_hits = r_in_hits;
        n_hits    = r_hits;
        n_tag     = r_tag;
        n_trig    = r_trig;
        n_col     = r_col;
        n_row     = r_row;
        n_cnt     = r_cnt;
        n_drop    = r_drop;
        o_push    = 1'b0;
        o_rec.err     = map_err;
        o_rec.slot    = slot;
        o_rec.hit_col = r_col;
        o_rec.hit_row = r_row;
        o_rec.charge  = count_word;
        o_rec.label   = (!quad && (i_cfg.front_end_type == FE_OLDER)) ?
                        {16'd0, r_trig} : r_tag;
        if (accept) begin
            n_pos     = e_pos;
            n_in_hits = e_in_hits;
            n_hits    = e_hits;
            n_drop    = e_drop;
            if (!e_drop) begin
                n_pos = e_pos + 4'd1;
                if (!e_in_hits) begin
                    case (e_pos)
                        POS_TAG_B0:  n_tag  = {24'd0, b};
                        POS_TAG_B1:  n_tag[15:8]  = b;
                        POS_TAG_B2:  n_tag[23:16] = b;
                        POS_TAG_B3:  n_tag[31:24] = b;
                        POS_TRIG_LO: n_trig = {8'd0, b};
                        POS_TRIG_HI: n_trig[15:8] = b;
                        POS_BCID_LO: ;
                        POS_BCID_HI: ;
                        POS_CNT_LO:  n_cnt  = b;
                        POS_CNT_HI: begin
                            n_hits    = count_word;
                            n_in_hits = count_word != 16'd0;
                            n_pos     = 4'd0;
                        end
                        default: n_pos = 4'd0;
                    endcase
                end else begin
                    case (e_pos)
                        POS_COL_LO: n_col = {8'd0, b};
                        POS_COL_HI: n_col[15:8] = b;
                        POS_ROW_LO: n_row = {8'd0, b};
                        POS_ROW_HI: n_row[15:8] = b;
                        POS_CHG_LO: n_cnt = b;
                        POS_CHG_HI: begin
                            o_push    = 1'b1;
                            n_pos     = 4'd0;
                            n_hits    = hits_dec;
                            n_in_hits = hits_dec != 16'd0;
                            if (map_err) begin
                                n_drop    = 1'b1;
                                n_in_hits = 1'b0;
                                n_hits    = 16'd0;
                            end
                        end
                        default: n_pos = 4'd0;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 4'd0;
            r_in_hits <= 1'b0;
            r_hits    <= 16'd0;
            r_tag     <= 32'd0;
            r_trig    <= 16'd0;
            r_col     <= 16'd0;
            r_row     <= 16'd0;
            r_cnt     <= 8'd0;
            r_drop    <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_in_hits <= n_in_hits;
            r_hits    <= n_hits;
            r_tag     <= n_tag;
            r_trig    <= n_trig;
            r_col     <= n_col;
            r_row     <= n_row;
            r_cnt     <= n_cnt;
            r_drop    <= n_drop;
        end
    end

`ifndef NO_ASSERTIONS
    a_push_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> accept)
        else $error("hit record pushed without an input beat");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_hits && r_pos <= POS_CHG_HI) || (!r_in_hits && r_pos <= POS_CNT_HI))
        else $error("parser byte position out of range");
    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> (!r_in_hits && r_hits == 16'd0 && r_pos == 4'd0))
        else $error("dropped block left hit list state");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/phfd_queue.sv -----
// short queue of hit records between parser and mapper
`default_nettype none

module phfd_queue
    import phfd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_hit_rec i_rec,
    output logic          o_space,
    output logic          o_valid,
    output t_hit_rec      o_rec,
    input  wire logic     i_pop
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_hit_rec      r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    assign o_space = r_count != CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_rec   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + AW'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push |-> o_space) and (i_pop |-> o_valid))
        else $error("queue pushed while full or popped while empty");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/phfd_back.sv -----
// coordinate and plane mapping of hit records into the output register
`default_nettype none

module phfd_back
    import phfd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_valid,
    input  wire t_hit_rec i_rec,
    output logic          o_pop,
    phfd_out_if.source    o_out
);

    logic        r_valid, n_valid;
    logic [12:0] r_plane_id, n_plane_id;
    logic [15:0] r_pixel_col, n_pixel_col;
    logic [15:0] r_pixel_row, n_pixel_row;
    logic [15:0] r_charge, n_charge;
    logic [31:0] r_label, n_label;
    logic        r_error, n_error;

    logic        quad;
    logic [2:0]  loc;
    logic [3:0]  mod_idx;
    logic [12:0] plane;
    logic [15:0] m_col;
    logic [15:0] m_row;

    assign quad    = i_cfg.quad_module_mask[i_rec.slot];
    assign loc     = i_cfg.chip_location_table[3*i_rec.slot +: 3];
    assign mod_idx = i_cfg.module_index_table[4*i_rec.slot +: 4];
    // 20 * producer as 16x + 4x
    assign plane   = PLANE_BASE + {1'b0, i_cfg.producer_number, 4'd0}
                     + {3'd0, i_cfg.producer_number, 2'd0} + {9'd0, mod_idx};

    always_comb begin
        m_col = i_rec.hit_col - 16'd1;
        m_row = i_rec.hit_row - 16'd1;
        if (quad) begin
            case (loc)
                LOC_1: begin
                    m_col = QUAD_HALF_COLS - i_rec.hit_row;
                    m_row = QUAD_FULL_ROWS - i_rec.hit_col;
                end
                LOC_2: begin
                    m_col = QUAD_HALF_COLS - i_rec.hit_row;
                    m_row = CHIP_ROWS_SPAN - i_rec.hit_col;
                end
                LOC_3: begin
                    m_col = (QUAD_HALF_COLS - 16'd1) + i_rec.hit_row;
                    m_row = i_rec.hit_col - 16'd1;
                end
                LOC_4: begin
                    m_col = (QUAD_HALF_COLS - 16'd1) + i_rec.hit_row;
                    m_row = (CHIP_ROWS_SPAN - 16'd1) + i_rec.hit_col;
                end
                default: begin
                    m_col = 16'd0;
                    m_row = 16'd0;
                end
            endcase
        end
    end

    assign o_pop = i_valid && (!r_valid || o_out.ready);

    always_comb begin
        n_valid     = r_valid;
        n_plane_id  = r_plane_id;
        n_pixel_col = r_pixel_col;
        n_pixel_row = r_pixel_row;
        n_charge    = r_charge;
        n_label     = r_label;
        n_error     = r_error;
        if (o_pop) begin
            n_valid = 1'b1;
            if (i_rec.err) begin
                n_plane_id  = 13'd0;
                n_pixel_col = 16'd0;
                n_pixel_row = 16'd0;
                n_charge    = 16'd0;
                n_label     = 32'd0;
                n_error     = 1'b1;
            end else begin
                n_plane_id  = plane;
                n_pixel_col = m_col;
                n_pixel_row = m_row;
                n_charge    = i_rec.charge;
                n_label     = i_rec.label;
                n_error     = 1'b0;
            end
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plane_id  <= n_plane_id;
        r_pixel_col <= n_pixel_col;
        r_pixel_row <= n_pixel_row;
        r_charge    <= n_charge;
        r_label     <= n_label;
        r_error     <= n_error;
    end

    assign o_out.valid         = r_valid;
    assign o_out.plane_id      = r_plane_id;
    assign o_out.pixel_col     = r_pixel_col;
    assign o_out.pixel_row     = r_pixel_row;
    assign o_out.charge        = r_charge;
    assign o_out.trigger_label = r_label;
    assign o_out.error         = r_error;

`ifndef NO_ASSERTIONS
    a_error_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_error) |-> (r_plane_id == 13'd0 && r_pixel_col == 16'd0
            && r_pixel_row == 16'd0 && r_charge == 16'd0 && r_label == 32'd0))
        else $error("error beat carries nonzero payload");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/pixel_hit_fragment_deframer_core.sv -----
// Pixel hit fragment deframer. Takes a chip's raw readout block one byte per beat
// (little endian: 32-bit tag, trigger id, bunch id, hit count, then column/row/charge
// per hit) and sends one pixel beat per completed hit, mapped to quad or single
// module coordinates, or one error beat after which the rest of the block is dropped
// until first_of_block. Input bytes are taken one per cycle; the parser front end
// stalls only when its QUEUE_DEPTH-entry hit queue is full, which happens only when
// the output side is held off. A completed hit goes into the hit queue at the edge
// taking its last byte, then into the output register once free. Registers are
// written through the configuration channel, which is always ready, and must only
// change while the block is idle.
`default_nettype none

module pixel_hit_fragment_deframer_core
    import phfd_pkg::*;
#(
    parameter int unsigned MAX_CHIP_SLOTS = MAX_CHIP_SLOTS_DEF,
    parameter int unsigned QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    phfd_cfg_if.sink    i_cfg,
    phfd_in_if.sink     i_in,
    phfd_out_if.source  o_out
);

    t_cfg     r_cfg;
    logic     q_space;
    logic     f_push;
    t_hit_rec f_rec;
    logic     q_valid;
    t_hit_rec q_rec;
    logic     b_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FRONT_END_TYPE:      r_cfg.front_end_type      <= i_cfg.data[1:0];
                CFG_PRODUCER_NUMBER:     r_cfg.producer_number     <= i_cfg.data[7:0];
                CFG_QUAD_MODULE_MASK:    r_cfg.quad_module_mask    <= i_cfg.data[15:0];
                CFG_CHIP_LOCATION_TABLE: r_cfg.chip_location_table <= i_cfg.data[47:0];
                CFG_MODULE_INDEX_TABLE:  r_cfg.module_index_table  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    phfd_front #(
        .MAX_CHIP_SLOTS (MAX_CHIP_SLOTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_space (q_space),
        .i_in    (i_in),
        .o_push  (f_push),
        .o_rec   (f_rec)
    );

    phfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_rec   (f_rec),
        .o_space (q_space),
        .o_valid (q_valid),
        .o_rec   (q_rec),
        .i_pop   (b_pop)
    );

    phfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_rec   (q_rec),
        .o_pop   (b_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ----- dv/tb_pixel_hit_fragment_deframer_core.sv -----
// self-checking testbench of the pixel hit fragment deframer: random blocks against a predictor
`timescale 1ns / 1ps

module tb_pixel_hit_fragment_deframer_core;
    import phfd_pkg::*;

    localparam int CLK_HALF_NS  = 5;
    localparam int RESET_CYCLES = 4;
    localparam int IDLE_PCT     = 27;
    localparam int CALM_START   = 800;
    localparam int CALM_END     = 1600;
    localparam int DRAIN_CYCLES = 12;
    localparam int PLANE_STRIDE = 20;
    localparam int TIMEOUT_NS   = 2_000_000;

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] slot;
        logic       first;
    } t_raw_beat;

    typedef struct packed {
        logic [12:0] plane;
        logic [15:0] col;
        logic [15:0] row;
        logic [15:0] charge;
        logic [31:0] label;
        logic        err;
    } t_pixel_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    phfd_in_if  in_if();
    phfd_out_if out_if();
    phfd_cfg_if cfg_if();

    pixel_hit_fragment_deframer_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_raw_beat   bytes_pending[$];
    t_raw_beat   block_bytes[$];
    t_pixel_beat pixels_due[$];
    t_pixel_beat due_px;

    t_cfg        cfg_shadow = '0;

    // predictor state
    logic [3:0]  pos       = '0;
    logic        in_hits   = 1'b0;
    logic [15:0] hits_left = '0;
    logic [31:0] tag       = '0;
    logic [15:0] trig      = '0;
    logic [15:0] hit_col   = '0;
    logic [15:0] hit_row   = '0;
    logic [7:0]  low_b     = '0;
    logic        dropping  = 1'b0;

    logic in_took       = 1'b0;
    int   cycle_no      = 0;
    int   failures      = 0;
    int   bytes_sent    = 0;
    int   pixels_seen   = 0;
    int   error_beats   = 0;
    int   settings_used = 0;

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    function automatic logic take_break();
        return (cycle_no < CALM_START || cycle_no >= CALM_END)
            && ($urandom_range(99) < IDLE_PCT);
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %h, actual %h", $time, what, want, got);
            failures++;
        end
    endfunction

    task automatic deframe_byte(input t_raw_beat rb);
        t_pixel_beat px;
        logic [15:0] new_col;
        logic [15:0] new_row;
        logic [2:0]  loc;
        logic        ok;
        if (rb.first) begin
            pos       = '0;
            in_hits   = 1'b0;
            hits_left = '0;
            dropping  = 1'b0;
        end
        if (!dropping && !in_hits) begin
            case (pos)
                POS_TAG_B0:  tag = {24'd0, rb.data};
                POS_TAG_B1:  tag[15:8] = tag[15:8] | rb.data;
                POS_TAG_B2:  tag[23:16] = tag[23:16] | rb.data;
                POS_TAG_B3:  tag[31:24] = tag[31:24] | rb.data;
                POS_TRIG_LO: trig = {8'd0, rb.data};
                POS_TRIG_HI: trig[15:8] = trig[15:8] | rb.data;
                POS_CNT_LO:  low_b = rb.data;
                POS_CNT_HI: begin
                    hits_left = {rb.data, low_b};
                    in_hits   = (hits_left != 16'd0);
                end
                default: ;
            endcase
            pos = (pos >= POS_CNT_HI) ? POS_TAG_B0 : pos + 4'd1;
        end else if (!dropping) begin
            case (pos)
                POS_COL_LO: hit_col = {8'd0, rb.data};
                POS_COL_HI: hit_col[15:8] = hit_col[15:8] | rb.data;
                POS_ROW_LO: hit_row = {8'd0, rb.data};
                POS_ROW_HI: hit_row[15:8] = hit_row[15:8] | rb.data;
                POS_CHG_LO: low_b = rb.data;
                POS_CHG_HI: begin
                    hits_left = hits_left - 16'd1;
                    if (hits_left == 16'd0) in_hits = 1'b0;
                    px       = '0;
                    ok       = 1'b1;
                    new_col  = '0;
                    new_row  = '0;
                    px.label = tag;
                    loc      = cfg_shadow.chip_location_table[3 * rb.slot +: 3];
                    if (cfg_shadow.front_end_type == FE_RESERVED) begin
                        ok = 1'b0;
                    end else if (cfg_shadow.quad_module_mask[rb.slot]) begin
                        if (cfg_shadow.front_end_type == FE_OLDER) begin
                            ok = 1'b0;
                        end else begin
                            case (loc)
                                LOC_1: begin
                                    new_col = QUAD_HALF_COLS - hit_row;
                                    new_row = QUAD_FULL_ROWS - hit_col;
                                end
                                LOC_2: begin
                                    new_col = QUAD_HALF_COLS - hit_row;
                                    new_row = CHIP_ROWS_SPAN - hit_col;
                                end
                                LOC_3: begin
                                    new_col = QUAD_HALF_COLS - 16'd1 + hit_row;
                                    new_row = hit_col - 16'd1;
                                end
                                LOC_4: begin
                                    new_col = QUAD_HALF_COLS - 16'd1 + hit_row;
                                    new_row = CHIP_ROWS_SPAN - 16'd1 + hit_col;
                                end
                                default: ok = 1'b0;
                            endcase
                        end
                    end else begin
                        new_col = hit_col - 16'd1;
                        new_row = hit_row - 16'd1;
                        if (cfg_shadow.front_end_type == FE_OLDER) px.label = {16'd0, trig};
                    end
                    if (ok) begin
                        px.plane  = PLANE_BASE
                                  + 13'(PLANE_STRIDE * cfg_shadow.producer_number)
                                  + 13'(cfg_shadow.module_index_table[4 * rb.slot +: 4]);
                        px.col    = new_col;
                        px.row    = new_row;
                        px.charge = {rb.data, low_b};
                    end else begin
                        px        = '0;
                        px.err    = 1'b1;
                        dropping  = 1'b1;
                        in_hits   = 1'b0;
                        hits_left = '0;
                    end
                    pixels_due.insert(pixels_due.size(), px);
                end
                default: ;
            endcase
            pos = (pos >= POS_CHG_HI) ? POS_COL_LO : pos + 4'd1;
        end
    endtask

    // input channel: drive at the falling edge, hold until the beat is taken
    always @(negedge i_clk) begin
        if (!(in_if.valid && !in_took)) begin
            if (i_rst_n && bytes_pending.size() != 0 && !take_break()) begin
                in_if.valid          <= 1'b1;
                in_if.data_byte      <= bytes_pending[0].data;
                in_if.chip_slot      <= bytes_pending[0].slot;
                in_if.first_of_block <= bytes_pending[0].first;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= !take_break();
    end

    always @(posedge i_clk) begin
        cycle_no++;
        in_took = in_if.valid && in_if.ready;
        if (in_took) deframe_byte(bytes_pending.pop_front());
    end

    always @(posedge i_clk) begin
        if (out_if.valid && out_if.ready) begin
            if (pixels_due.size() == 0) begin
                $display("%0t unexpected beat: expected none, actual plane %0d col %h row %h %s",
                         $time, out_if.plane_id, out_if.pixel_col, out_if.pixel_row,
                         $sformatf("charge %h label %h error %b", out_if.charge,
                                   out_if.trigger_label, out_if.error));
                failures++;
            end else begin
                due_px = pixels_due.pop_front();
                check_field("plane_id", due_px.plane, out_if.plane_id);
                check_field("pixel_col", due_px.col, out_if.pixel_col);
                check_field("pixel_row", due_px.row, out_if.pixel_row);
                check_field("charge", due_px.charge, out_if.charge);
                check_field("trigger_label", due_px.label, out_if.trigger_label);
                check_field("error", due_px.err, out_if.error);
                if (due_px.err) error_beats++;
                else pixels_seen++;
            end
        end
    end

    function automatic logic [15:0] pick_word();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(900));
            2: begin
                case ($urandom_range(3))
                    0: return 16'h0000;
                    1: return 16'h0001;
                    2: return 16'h8000;
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'($urandom_range(15));
        endcase
    endfunction

    function automatic logic [47:0] pick_locations(input logic valid_only);
        logic [47:0] locs;
        locs = '0;
        for (int s = 0; s < 16; s++) begin
            locs[3 * s +: 3] = valid_only ? 3'($urandom_range(1, 4)) : 3'($urandom_range(7));
        end
        return locs;
    endfunction

    task automatic add_le(input logic [31:0] val, input int nbytes, input logic [3:0] slot);
        for (int i = 0; i < nbytes; i++) begin
            block_bytes.insert(block_bytes.size(), t_raw_beat'{val[8 * i +: 8], slot, 1'b0});
        end
    endtask

    task automatic build_fragment(input logic [3:0] slot, input int nhits);
        add_le($urandom, 4, slot);
        add_le($urandom_range(65535), 2, slot);
        add_le($urandom, 2, slot);
        add_le(nhits, 2, slot);
        for (int h = 0; h < nhits; h++) begin
            add_le(pick_word(), 2, slot);
            add_le(pick_word(), 2, slot);
            add_le(pick_word(), 2, slot);
        end
    endtask

    task automatic flush_block();
        while (block_bytes.size() != 0) begin
            bytes_pending.insert(bytes_pending.size(), block_bytes.pop_front());
            bytes_sent++;
        end
    endtask

    task automatic gen_block();
        logic [3:0] slot;
        int         nfrag;
        int         v;
        int         n;
        block_bytes.delete();
        slot  = 4'($urandom_range(15));
        nfrag = $urandom_range(1, 3);
        for (int f = 0; f < nfrag; f++) begin
            build_fragment(slot, ($urandom_range(9) < 8) ? $urandom_range(4)
                                                          : $urandom_range(5, 12));
        end
        block_bytes[0].first = 1'b1;
        v = $urandom_range(99);
        if (v < 12) begin
            n = $urandom_range(1, block_bytes.size() - 1);
            while (block_bytes.size() > n) void'(block_bytes.pop_back());
        end else if (v < 20) begin
            foreach (block_bytes[i]) block_bytes[i].slot = 4'($urandom_range(15));
        end else if (v < 25) begin
            block_bytes[0].first = 1'b0;
        end else if (v < 32) begin
            block_bytes.delete();
            n = $urandom_range(1, 24);
            for (int i = 0; i < n; i++) begin
                block_bytes.insert(block_bytes.size(),
                                   t_raw_beat'{8'($urandom), 4'($urandom),
                                               $urandom_range(15) == 0});
            end
        end
        flush_block();
    endtask

    task automatic random_phase(input int nbytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < nbytes) gen_block();
    endtask

    task automatic drain();
        while (bytes_pending.size() != 0 || pixels_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_FRONT_END_TYPE:      cfg_shadow.front_end_type = val[1:0];
            CFG_PRODUCER_NUMBER:     cfg_shadow.producer_number = val[7:0];
            CFG_QUAD_MODULE_MASK:    cfg_shadow.quad_module_mask = val[15:0];
            CFG_CHIP_LOCATION_TABLE: cfg_shadow.chip_location_table = val[47:0];
            CFG_MODULE_INDEX_TABLE:  cfg_shadow.module_index_table = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [1:0] fe, input logic [7:0] prod,
                                  input logic [15:0] mask, input logic [47:0] locs,
                                  input logic [63:0] idx);
        drain();
        write_reg(CFG_FRONT_END_TYPE, 64'(fe));
        write_reg(CFG_PRODUCER_NUMBER, 64'(prod));
        write_reg(CFG_QUAD_MODULE_MASK, 64'(mask));
        write_reg(CFG_CHIP_LOCATION_TABLE, 64'(locs));
        write_reg(CFG_MODULE_INDEX_TABLE, idx);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    initial begin
        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.data_byte      = '0;
        in_if.chip_slot      = '0;
        in_if.first_of_block = 1'b0;
        out_if.ready         = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_FRONT_END_TYPE;
        cfg_if.data          = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: older front end, all single modules
        block_bytes.delete();
        add_le(32'hFFFF_FFFF, 4, 4'hF);
        add_le(16'hFFFF, 2, 4'hF);
        add_le(16'hFFFF, 2, 4'hF);
        add_le(16'd1, 2, 4'hF);
        add_le(16'h0000, 2, 4'hF);
        add_le(16'h0000, 2, 4'hF);
        add_le(16'hFFFF, 2, 4'hF);
        block_bytes[0].first = 1'b1;
        // fragment with zero hit count
        add_le(32'h0, 4, 4'h0);
        add_le(16'h0, 2, 4'h0);
        add_le(16'h0, 2, 4'h0);
        add_le(16'h0, 2, 4'h0);
        flush_block();
        random_phase(240);

        apply_settings(FE_NEWER, 8'hFF, 16'hFFFF, pick_locations(1'b1), '1);
        random_phase(260);
        apply_settings(FE_NEWEST, 8'($urandom), 16'($urandom), pick_locations(1'b1),
                       {$urandom, $urandom});
        random_phase(260);
        // quad modules with the older front end are undefined
        apply_settings(FE_OLDER, 8'($urandom), 16'($urandom & $urandom),
                       pick_locations(1'b0), {$urandom, $urandom});
        random_phase(220);
        apply_settings(FE_RESERVED, 8'h00, 16'h0000, '0, '0);
        random_phase(100);
        apply_settings(FE_NEWER, 8'($urandom), 16'($urandom), pick_locations(1'b0),
                       {$urandom, $urandom});
        random_phase(260);
        apply_settings(FE_NEWEST, 8'h00, 16'h0000, '1, '0);
        random_phase(240);
        // every slot quad with an undefined location
        apply_settings(FE_NEWEST, 8'hFF, 16'hFFFF, '1, '0);
        random_phase(100);

        drain();
        if (pixels_due.size() != 0) begin
            $display("%0t %0d pixel beats expected, actual none", $time, pixels_due.size());
            failures++;
        end
        $display("sent %0d readout bytes under %0d register settings after reset",
                 bytes_sent, settings_used);
        $display("checked %0d pixel beats and %0d error beats, %0d mismatches",
                 pixels_seen, error_beats, failures);
        if (failures == 0) begin
            $display("[pixel_hit_fragment_deframer_core] OK");
        end else begin
            $display("[pixel_hit_fragment_deframer_core] ERROR");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("%0t timeout with %0d bytes and %0d pixel beats outstanding",
                 $time, bytes_pending.size(), pixels_due.size());
        $display("[pixel_hit_fragment_deframer_core] ERROR");
        $finish;
    end

endmodule
